// ===== hdl/note_sequence_player_top_defines.svh =====
// assertion macros for the note sequence player
`ifndef NOTE_SEQUENCE_PLAYER_TOP_DEFINES_SVH
`define NOTE_SEQUENCE_PLAYER_TOP_DEFINES_SVH

// same-cycle implication
`define NSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nsp_pkg.sv =====
package nsp_pkg;

  localparam int SEQ_DEPTH    = 64;
  localparam int ACTIVE_NOTES = 8;
  localparam int NOTE_BITS    = 16;

  localparam int CMD_W       = 3;
  localparam int INDEX_W     = 6;
  localparam int NOTE_PORT_W = 16;
  localparam int TICK_W      = 16;
  localparam int TIME_W      = 32;
  localparam int LEN_CFG_W   = 7;

  localparam int ADDR_W  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int LEN_W   = $clog2(SEQ_DEPTH + 1);
  localparam int SLOT_W  = (ACTIVE_NOTES > 1) ? $clog2(ACTIVE_NOTES) : 1;
  localparam int CNT_W   = $clog2(ACTIVE_NOTES + 1);
  localparam int ENTRY_W = NOTE_BITS + 2 * TICK_W + 1;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_START  = 3'd1,
    CMD_RESUME = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_CHECK,
    S_STEP_CHECK,
    S_READ,
    S_PLAY,
    S_EVICT,
    S_NOTE_ON,
    S_SCAN,
    S_STOP_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic cap_item;
    logic ram_we;
    logic tick_inc;
    logic start_seq;
    logic resume;
    logic set_stop;
    logic step_zero;
    logic step_adv;
    logic load_step_time;
    logic evict;
    logic append_on;
    logic emit_scan;
    logic remove_scan;
    logic slot_clr;
    logic slot_inc;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic load_ok;
    logic len_zero;
    logic playing;
    logic can_restart;
    logic step_due;
    logic adv_in_range;
    logic entry_mute;
    logic list_full;
    logic slot_done;
    logic release_due;
    logic emit_ok;
    logic pend_valid;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== hdl/nsp_in_if.sv =====
interface nsp_in_if;
  logic                            valid;
  logic                            ready;
  logic [nsp_pkg::CMD_W-1:0]       cmd;
  logic [nsp_pkg::INDEX_W-1:0]     entry_index;
  logic [nsp_pkg::NOTE_PORT_W-1:0] note_word;
  logic [nsp_pkg::TICK_W-1:0]      on_ticks;
  logic [nsp_pkg::TICK_W-1:0]      step_ticks;
  logic                            muted;
  logic                            loop_flag;

  modport source (
    output valid, cmd, entry_index, note_word, on_ticks, step_ticks, muted, loop_flag,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, note_word, on_ticks, step_ticks, muted, loop_flag,
    output ready
  );
endinterface

// ===== hdl/nsp_out_if.sv =====
interface nsp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            event_kind;
  logic [nsp_pkg::NOTE_PORT_W-1:0] event_note;
  logic                            last;

  modport source (
    output valid, event_kind, event_note, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_note, last,
    output ready
  );
endinterface

// ===== hdl/note_sequence_player_top.sv =====
// note sequence player: a step sequencer driven by tick items
// note_cmd carries one command item per valid/ready handshake: load a
// sequence entry, start, resume, stop or tick. note_event returns note-on and
// note-off items; last marks the final event item caused by a command.
// cfg_wr_en/cfg_wr_data write the sequence length; the user must write it only while idle, not enforced.
// note_cmd is taken one item at a time, only in the idle state.
// load, resume and unknown commands cause no events.
// start: events for the first entry only (none with zero length); the sequence store
// is a RAM with registered read, so each step is read in S_READ before S_PLAY.
// stop: one note-off per sounding note.
// tick: no events when nothing plays, else one note-off per released active note;
// a restart or a played step adds a read of its entry and the events it causes.
// an event is held back until the next one is made; the final one leaves
// from the flush state.
// reset clears all control state and the active list, sets the stopped
// flag and the length to zero; the store is undefined until loaded.
// a stalled receiver holds the event register; the block waits and takes no
// new command until the final event of the current one is in the event register.
`include "note_sequence_player_top_defines.svh"

module note_sequence_player_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [nsp_pkg::LEN_CFG_W-1:0]   cfg_wr_data,
  nsp_in_if.sink                          note_cmd,
  nsp_out_if.source                       note_event
);

  nsp_pkg::ctrl_cmd_t    ctl;
  nsp_pkg::ctrl_status_t sts;

  nsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (note_cmd.valid),
    .in_ready (note_cmd.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  nsp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_cmd         (note_cmd.cmd),
    .in_entry_index (note_cmd.entry_index),
    .in_note_word   (note_cmd.note_word),
    .in_on_ticks    (note_cmd.on_ticks),
    .in_step_ticks  (note_cmd.step_ticks),
    .in_muted       (note_cmd.muted),
    .in_loop_flag   (note_cmd.loop_flag),
    .out_ready      (note_event.ready),
    .out_valid      (note_event.valid),
    .out_event_kind (note_event.event_kind),
    .out_event_note (note_event.event_note),
    .out_last       (note_event.last),
    .ctl            (ctl),
    .sts            (sts)
  );

  `NSP_ASSERT_IMP(a_idle_no_pending, note_cmd.ready, !sts.pend_valid, "item taken with event pending")
  `NSP_ASSERT_IMP(a_append_not_full, ctl.append_on, !sts.list_full, "note added to full list")
  `NSP_ASSERT_IMP(a_emit_has_room, ctl.evict || ctl.append_on || ctl.emit_scan, sts.emit_ok, "event lost")
  `NSP_ASSERT_NXT(a_one_item, note_cmd.valid && note_cmd.ready, !note_cmd.ready, "second item taken")

endmodule

// ===== hdl/nsp_ram.sv =====
module nsp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/nsp_datapath.sv =====
module nsp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [nsp_pkg::LEN_CFG_W-1:0]        cfg_wr_data,
  input  logic [nsp_pkg::CMD_W-1:0]            in_cmd,
  input  logic [nsp_pkg::INDEX_W-1:0]          in_entry_index,
  input  logic [nsp_pkg::NOTE_PORT_W-1:0]      in_note_word,
  input  logic [nsp_pkg::TICK_W-1:0]           in_on_ticks,
  input  logic [nsp_pkg::TICK_W-1:0]           in_step_ticks,
  input  logic                                 in_muted,
  input  logic                                 in_loop_flag,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_event_kind,
  output logic [nsp_pkg::NOTE_PORT_W-1:0]      out_event_note,
  output logic                                 out_last,
  input  nsp_pkg::ctrl_cmd_t                   ctl,
  output nsp_pkg::ctrl_status_t                sts
);

  localparam int N = nsp_pkg::ACTIVE_NOTES;

  // captured item
  logic [nsp_pkg::CMD_W-1:0]       cmd_q;
  logic [nsp_pkg::INDEX_W-1:0]     idx_q;
  logic [nsp_pkg::NOTE_BITS-1:0]   word_q;
  logic [nsp_pkg::TICK_W-1:0]      on_q;
  logic [nsp_pkg::TICK_W-1:0]      step_q;
  logic                            mute_q;
  logic                            loop_q;

  logic [nsp_pkg::LEN_CFG_W-1:0]   seq_len_cfg;
  logic [nsp_pkg::LEN_W-1:0]       seq_len;
  logic [nsp_pkg::LEN_W-1:0]       step_pos;
  logic [nsp_pkg::LEN_W:0]         step_inc;
  logic [nsp_pkg::LEN_W-1:0]       step_sat;
  logic [nsp_pkg::TIME_W-1:0]      next_step_time;
  logic [nsp_pkg::TIME_W-1:0]      tick_time;
  logic                            stopped;
  logic                            loop_en;
  logic                            present;

  logic [nsp_pkg::NOTE_BITS-1:0]   act_word [N];
  logic [nsp_pkg::TIME_W-1:0]      act_rel  [N];
  logic [nsp_pkg::CNT_W-1:0]       act_count;
  logic [nsp_pkg::CNT_W-1:0]       slot;
  logic [nsp_pkg::SLOT_W-1:0]      slot_i;
  logic [nsp_pkg::SLOT_W-1:0]      rm_idx;
  logic                            shift;

  logic                            pend_valid;
  logic                            pend_kind;
  logic [nsp_pkg::NOTE_BITS-1:0]   pend_word;
  logic                            out_free;
  logic                            out_load;
  logic                            emit;
  logic                            emit_kind;
  logic [nsp_pkg::NOTE_BITS-1:0]   emit_word;

  logic [nsp_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [nsp_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [nsp_pkg::NOTE_BITS-1:0]   e_word;
  logic [nsp_pkg::TICK_W-1:0]      e_on;
  logic [nsp_pkg::TICK_W-1:0]      e_step;
  logic                            e_mute;

  // entry layout: mute, step, on, word
  assign ram_wdata = {mute_q, step_q, on_q, word_q};
  assign e_word    = ram_rdata[nsp_pkg::NOTE_BITS-1:0];
  assign e_on      = ram_rdata[nsp_pkg::NOTE_BITS +: nsp_pkg::TICK_W];
  assign e_step    = ram_rdata[nsp_pkg::NOTE_BITS + nsp_pkg::TICK_W +: nsp_pkg::TICK_W];
  assign e_mute    = ram_rdata[nsp_pkg::ENTRY_W-1];

  nsp_ram #(
    .WIDTH  (nsp_pkg::ENTRY_W),
    .DEPTH  (nsp_pkg::SEQ_DEPTH),
    .ADDR_W (nsp_pkg::ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (nsp_pkg::ADDR_W'(idx_q)),
    .wdata (ram_wdata),
    .raddr (step_pos[nsp_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (32'(seq_len_cfg) > 32'(nsp_pkg::SEQ_DEPTH)) begin
      seq_len = nsp_pkg::LEN_W'(nsp_pkg::SEQ_DEPTH);
    end else begin
      seq_len = nsp_pkg::LEN_W'(seq_len_cfg);
    end
  end

  assign step_inc = {1'b0, step_pos} + (nsp_pkg::LEN_W + 1)'(1);
  assign step_sat = (step_inc > {1'b0, seq_len}) ? seq_len : step_inc[nsp_pkg::LEN_W-1:0];

  assign slot_i = slot[nsp_pkg::SLOT_W-1:0];
  assign rm_idx = ctl.evict ? '0 : slot_i;
  assign shift  = ctl.evict | ctl.remove_scan;

  assign out_free = !out_valid || out_ready;
  assign emit     = ctl.evict | ctl.append_on | ctl.emit_scan;
  assign out_load = (emit && pend_valid) || ctl.flush;

  always_comb begin
    emit_kind = ctl.append_on ? nsp_pkg::KIND_ON : nsp_pkg::KIND_OFF;
    if (ctl.evict) begin
      emit_word = act_word[0];
    end else if (ctl.append_on) begin
      emit_word = e_word;
    end else begin
      emit_word = act_word[slot_i];
    end
  end

  always_comb begin
    sts.cmd          = nsp_pkg::cmd_t'(cmd_q);
    sts.load_ok      = 32'(idx_q) < 32'(nsp_pkg::SEQ_DEPTH);
    sts.len_zero     = (seq_len == '0);
    sts.playing      = present && !stopped && ((step_pos < seq_len) || (act_count != '0));
    sts.can_restart  = loop_en && present && !stopped;
    sts.step_due     = tick_time >= next_step_time;
    sts.adv_in_range = step_sat < seq_len;
    sts.entry_mute   = e_mute;
    sts.list_full    = (act_count == nsp_pkg::CNT_W'(N));
    sts.slot_done    = slot >= act_count;
    sts.release_due  = tick_time >= act_rel[slot_i];
    sts.emit_ok      = !pend_valid || out_free;
    sts.pend_valid   = pend_valid;
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_item) begin
      cmd_q  <= in_cmd;
      idx_q  <= in_entry_index;
      word_q <= nsp_pkg::NOTE_BITS'(in_note_word);
      on_q   <= in_on_ticks;
      step_q <= in_step_ticks;
      mute_q <= in_muted;
      loop_q <= in_loop_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len_cfg    <= '0;
      step_pos       <= '0;
      next_step_time <= '0;
      tick_time      <= '0;
      stopped        <= 1'b1;
      loop_en        <= 1'b0;
      present        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seq_len_cfg <= cfg_wr_data;
      end
      if (ctl.tick_inc) begin
        tick_time <= tick_time + nsp_pkg::TIME_W'(1);
      end
      if (ctl.start_seq) begin
        present <= 1'b1;
        loop_en <= loop_q;
      end
      if (ctl.resume) begin
        loop_en <= loop_q;
        stopped <= 1'b0;
      end
      if (ctl.set_stop) begin
        stopped <= 1'b1;
      end
      if (ctl.step_zero) begin
        step_pos <= '0;
        stopped  <= 1'b0;
      end else if (ctl.step_adv) begin
        step_pos <= step_sat;
      end
      if (ctl.load_step_time) begin
        next_step_time <= tick_time + nsp_pkg::TIME_W'(e_step);
      end
    end
  end

  // active list, oldest first
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (shift && (nsp_pkg::SLOT_W'(k) >= rm_idx) && (k < N - 1)) begin
        act_word[k] <= act_word[nsp_pkg::SLOT_W'((k + 1) % N)];
        act_rel[k]  <= act_rel[nsp_pkg::SLOT_W'((k + 1) % N)];
      end else if (ctl.append_on && (act_count == nsp_pkg::CNT_W'(k))) begin
        act_word[k] <= e_word;
        act_rel[k]  <= tick_time + nsp_pkg::TIME_W'(e_on);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_count <= '0;
      slot      <= '0;
    end else begin
      if (ctl.set_stop) begin
        act_count <= '0;
      end else if (shift) begin
        act_count <= act_count - nsp_pkg::CNT_W'(1);
      end else if (ctl.append_on) begin
        act_count <= act_count + nsp_pkg::CNT_W'(1);
      end
      if (ctl.slot_clr) begin
        slot <= '0;
      end else if (ctl.slot_inc) begin
        slot <= slot + nsp_pkg::CNT_W'(1);
      end
    end
  end

  // one event held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (ctl.flush) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_kind <= emit_kind;
      pend_word <= emit_word;
    end
    if (out_load) begin
      out_event_kind <= pend_kind;
      out_event_note <= nsp_pkg::NOTE_PORT_W'(pend_word);
      out_last       <= ctl.flush;
    end
  end

endmodule

// ===== hdl/nsp_ctrl.sv =====
module nsp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nsp_pkg::ctrl_status_t sts,
  output nsp_pkg::ctrl_cmd_t    ctl
);

  nsp_pkg::state_t state, state_next;
  nsp_pkg::state_t ret_state, ret_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nsp_pkg::S_IDLE;
      ret_state <= nsp_pkg::S_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      nsp_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = nsp_pkg::S_DECODE;
        end
      end
      nsp_pkg::S_DECODE: begin
        unique case (sts.cmd)
          nsp_pkg::CMD_START: begin
            if (!sts.len_zero) begin
              ret_state_next = nsp_pkg::S_FLUSH;
              state_next     = nsp_pkg::S_READ;
            end else begin
              state_next = nsp_pkg::S_IDLE;
            end
          end
          nsp_pkg::CMD_STOP: state_next = nsp_pkg::S_STOP_SCAN;
          nsp_pkg::CMD_TICK: state_next = nsp_pkg::S_TICK_CHECK;
          default:           state_next = nsp_pkg::S_IDLE;
        endcase
      end
      nsp_pkg::S_TICK_CHECK: begin
        if (sts.playing) begin
          state_next = nsp_pkg::S_STEP_CHECK;
        end else if (sts.can_restart) begin
          ret_state_next = nsp_pkg::S_STEP_CHECK;
          state_next     = nsp_pkg::S_READ;
        end else begin
          state_next = nsp_pkg::S_IDLE;
        end
      end
      nsp_pkg::S_STEP_CHECK: begin
        if (sts.step_due && sts.adv_in_range) begin
          ret_state_next = nsp_pkg::S_SCAN;
          state_next     = nsp_pkg::S_READ;
        end else begin
          state_next = nsp_pkg::S_SCAN;
        end
      end
      nsp_pkg::S_READ: state_next = nsp_pkg::S_PLAY;
      nsp_pkg::S_PLAY: begin
        priority if (sts.entry_mute) begin
          state_next = ret_state;
        end else if (sts.list_full) begin
          state_next = nsp_pkg::S_EVICT;
        end else begin
          state_next = nsp_pkg::S_NOTE_ON;
        end
      end
      nsp_pkg::S_EVICT: begin
        if (sts.emit_ok) begin
          state_next = nsp_pkg::S_NOTE_ON;
        end
      end
      nsp_pkg::S_NOTE_ON: begin
        if (sts.emit_ok) begin
          state_next = ret_state;
        end
      end
      nsp_pkg::S_SCAN: begin
        if (sts.slot_done) begin
          state_next = nsp_pkg::S_FLUSH;
        end
      end
      nsp_pkg::S_STOP_SCAN: begin
        if (sts.slot_done) begin
          state_next = nsp_pkg::S_FLUSH;
        end
      end
      nsp_pkg::S_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) begin
          state_next = nsp_pkg::S_IDLE;
        end
      end
      default: state_next = nsp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      nsp_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        ctl.cap_item = in_valid;
      end
      nsp_pkg::S_DECODE: begin
        unique case (sts.cmd)
          nsp_pkg::CMD_LOAD:   ctl.ram_we = sts.load_ok;
          nsp_pkg::CMD_START: begin
            ctl.start_seq = !sts.len_zero;
            ctl.step_zero = !sts.len_zero;
          end
          nsp_pkg::CMD_RESUME: ctl.resume   = 1'b1;
          nsp_pkg::CMD_STOP:   ctl.slot_clr = 1'b1;
          nsp_pkg::CMD_TICK:   ctl.tick_inc = 1'b1;
          default: ;
        endcase
      end
      nsp_pkg::S_TICK_CHECK: begin
        ctl.step_zero = !sts.playing && sts.can_restart;
      end
      nsp_pkg::S_STEP_CHECK: begin
        ctl.slot_clr = 1'b1;
        ctl.step_adv = sts.step_due;
      end
      nsp_pkg::S_PLAY: begin
        ctl.load_step_time = 1'b1;
      end
      nsp_pkg::S_EVICT: begin
        ctl.evict = sts.emit_ok;
      end
      nsp_pkg::S_NOTE_ON: begin
        ctl.append_on = sts.emit_ok;
      end
      nsp_pkg::S_SCAN: begin
        if (!sts.slot_done) begin
          if (sts.release_due) begin
            ctl.emit_scan   = sts.emit_ok;
            ctl.remove_scan = sts.emit_ok;
          end else begin
            ctl.slot_inc = 1'b1;
          end
        end
      end
      nsp_pkg::S_STOP_SCAN: begin
        if (sts.slot_done) begin
          ctl.set_stop = 1'b1;
        end else begin
          ctl.emit_scan = sts.emit_ok;
          ctl.slot_inc  = sts.emit_ok;
        end
      end
      nsp_pkg::S_FLUSH: begin
        ctl.flush = sts.pend_valid && sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== test/nsp_player_check_pkg.sv =====
package nsp_player_check_pkg;

  localparam logic [nsp_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [nsp_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [nsp_pkg::CMD_W-1:0]       cmd;
    logic [nsp_pkg::INDEX_W-1:0]     entry_index;
    logic [nsp_pkg::NOTE_PORT_W-1:0] note_word;
    logic [nsp_pkg::TICK_W-1:0]      on_ticks;
    logic [nsp_pkg::TICK_W-1:0]      step_ticks;
    logic                            muted;
    logic                            loop_flag;
  } note_cmd_t;

  typedef struct packed {
    logic                            kind;
    logic [nsp_pkg::NOTE_PORT_W-1:0] note;
    logic                            last;
  } note_event_t;

  typedef struct packed {
    bit [nsp_pkg::NOTE_PORT_W-1:0] note;
    bit [nsp_pkg::TIME_W-1:0]      release_at;
  } sounding_note_t;

  class note_event_tracker;
    bit [nsp_pkg::NOTE_PORT_W-1:0] seq_note [nsp_pkg::SEQ_DEPTH];
    bit [nsp_pkg::TICK_W-1:0]      seq_on   [nsp_pkg::SEQ_DEPTH];
    bit [nsp_pkg::TICK_W-1:0]      seq_step [nsp_pkg::SEQ_DEPTH];
    bit                            seq_mute [nsp_pkg::SEQ_DEPTH];
    sounding_note_t                sounding[$];
    note_event_t                   pending_events[$];
    note_event_t                   new_events[$];
    int unsigned                   position;
    bit [nsp_pkg::TIME_W-1:0]      next_step_at;
    bit [nsp_pkg::TIME_W-1:0]      now;
    bit                            halted;
    bit                            looping;
    bit                            have_sequence;
    bit [nsp_pkg::LEN_CFG_W-1:0]   length_reg;
    int                            errors;
    int                            commands;
    int                            ticks;
    int                            events;
    int                            evictions;

    function new();
      position      = 0;
      next_step_at  = '0;
      now           = '0;
      halted        = 1'b1;
      looping       = 1'b0;
      have_sequence = 1'b0;
      length_reg    = '0;
      errors        = 0;
      commands      = 0;
      ticks         = 0;
      events        = 0;
      evictions     = 0;
    endfunction

    function void set_length(bit [nsp_pkg::LEN_CFG_W-1:0] v);
      length_reg = v;
    endfunction

    function int unsigned play_length();
      return (length_reg > nsp_pkg::SEQ_DEPTH) ? nsp_pkg::SEQ_DEPTH : length_reg;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void emit(bit kind, bit [nsp_pkg::NOTE_PORT_W-1:0] note);
      note_event_t ev;
      ev.kind = kind;
      ev.note = note;
      ev.last = 1'b0;
      new_events = {new_events, ev};
    endfunction

    function void sound_current();
      sounding_note_t s;
      if (position >= nsp_pkg::SEQ_DEPTH) return;
      next_step_at = now + seq_step[position];
      if (seq_mute[position]) return;
      // full list: oldest note goes first
      if (sounding.size() >= nsp_pkg::ACTIVE_NOTES) begin
        s = sounding.pop_front();
        emit(nsp_pkg::KIND_OFF, s.note);
        evictions++;
      end
      s.note       = seq_note[position];
      s.release_at = now + seq_on[position];
      sounding = {sounding, s};
      emit(nsp_pkg::KIND_ON, seq_note[position]);
    endfunction

    function void restart();
      halted   = 1'b0;
      position = 0;
      sound_current();
    endfunction

    function void advance_tick();
      int unsigned len;
      int i;
      now = now + 1;
      if (!(have_sequence && !halted && (position < play_length() || sounding.size() > 0)))
      begin
        if (looping && have_sequence && !halted) restart();
        else return;
      end
      if (now >= next_step_at) begin
        len = play_length();
        position = (position + 1 > len) ? len : position + 1;
        if (position < len) sound_current();
      end
      i = 0;
      while (i < sounding.size()) begin
        if (now >= sounding[i].release_at) begin
          emit(nsp_pkg::KIND_OFF, sounding[i].note);
          sounding.delete(i);
        end else begin
          i++;
        end
      end
    endfunction

    function void accept_command(note_cmd_t c);
      commands++;
      new_events.delete();
      case (c.cmd)
        nsp_pkg::CMD_LOAD: begin
          seq_note[c.entry_index] = c.note_word;
          seq_on[c.entry_index]   = c.on_ticks;
          seq_step[c.entry_index] = c.step_ticks;
          seq_mute[c.entry_index] = c.muted;
        end
        nsp_pkg::CMD_START: begin
          if (play_length() > 0) begin
            have_sequence = 1'b1;
            looping       = c.loop_flag;
            restart();
          end
        end
        nsp_pkg::CMD_RESUME: begin
          looping = c.loop_flag;
          halted  = 1'b0;
        end
        nsp_pkg::CMD_STOP: begin
          foreach (sounding[k]) emit(nsp_pkg::KIND_OFF, sounding[k].note);
          sounding.delete();
          halted = 1'b1;
        end
        nsp_pkg::CMD_TICK: begin
          ticks++;
          advance_tick();
        end
        default: ;
      endcase
      if (new_events.size() > 0) new_events[new_events.size() - 1].last = 1'b1;
      pending_events = {pending_events, new_events};
    endfunction

    function void check_event(logic kind, logic [nsp_pkg::NOTE_PORT_W-1:0] note,
                              logic last);
      note_event_t want;
      events++;
      if (pending_events.size() == 0) begin
        $error("unexpected note event: event_kind %0d event_note 0x%04h last %0d",
               kind, note, last);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (kind !== want.kind) begin
        $error("event_kind mismatch: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (note !== want.note) begin
        $error("event_note mismatch: expected 0x%04h, got 0x%04h", want.note, note);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb_note_sequence_player_top.sv =====
module tb_note_sequence_player_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT      = 35;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 10;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [nsp_pkg::LEN_CFG_W-1:0] cfg_wr_data;

  nsp_in_if  cmd_if ();
  nsp_out_if event_if ();

  nsp_player_check_pkg::note_event_tracker tracker;
  int idle_pct = IDLE_PCT;
  int cycle_count;
  int settings;

  note_sequence_player_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .note_cmd    (cmd_if),
    .note_event  (event_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d note events still outstanding",
             cycle_count, tracker.pending());
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && event_if.valid && event_if.ready)
      tracker.check_event(event_if.event_kind, event_if.event_note, event_if.last);
    event_if.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
  end

  function automatic nsp_player_check_pkg::note_cmd_t make_cmd(
      input logic [nsp_pkg::CMD_W-1:0] cmd,
      input logic [nsp_pkg::INDEX_W-1:0] idx,
      input logic [nsp_pkg::NOTE_PORT_W-1:0] note,
      input logic [nsp_pkg::TICK_W-1:0] on_t,
      input logic [nsp_pkg::TICK_W-1:0] step_t,
      input logic mute,
      input logic loop_on);
    nsp_player_check_pkg::note_cmd_t c;
    c.cmd         = cmd;
    c.entry_index = idx;
    c.note_word   = note;
    c.on_ticks    = on_t;
    c.step_ticks  = step_t;
    c.muted       = mute;
    c.loop_flag   = loop_on;
    return c;
  endfunction

  function automatic nsp_player_check_pkg::note_cmd_t random_load(int on_max, int step_max);
    nsp_player_check_pkg::note_cmd_t c;
    c.cmd         = nsp_pkg::CMD_LOAD;
    c.entry_index = nsp_pkg::INDEX_W'($urandom);
    c.note_word   = nsp_pkg::NOTE_PORT_W'($urandom);
    c.on_ticks    = nsp_pkg::TICK_W'(($urandom_range(9) == 0) ? $urandom
                                                               : $urandom_range(on_max));
    c.step_ticks  = nsp_pkg::TICK_W'(($urandom_range(11) == 0) ? $urandom
                                                                : $urandom_range(step_max));
    c.muted       = ($urandom_range(5) == 0);
    c.loop_flag   = 1'($urandom);
    return c;
  endfunction

  function automatic nsp_player_check_pkg::note_cmd_t random_command();
    nsp_player_check_pkg::note_cmd_t c;
    int r;
    c = random_load(12, 4);
    r = $urandom_range(99);
    if (r < 58)      c.cmd = nsp_pkg::CMD_TICK;
    else if (r < 70) c.cmd = nsp_pkg::CMD_LOAD;
    else if (r < 78) c.cmd = nsp_pkg::CMD_START;
    else if (r < 85) c.cmd = nsp_pkg::CMD_STOP;
    else if (r < 94) c.cmd = nsp_pkg::CMD_RESUME;
    else             c.cmd = nsp_pkg::CMD_W'($urandom_range(
                                 nsp_player_check_pkg::CMD_UNKNOWN_HI,
                                 nsp_player_check_pkg::CMD_UNKNOWN_LO));
    return c;
  endfunction

  task automatic send_command(nsp_player_check_pkg::note_cmd_t c);
    int gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= c.cmd;
    cmd_if.entry_index <= c.entry_index;
    cmd_if.note_word   <= c.note_word;
    cmd_if.on_ticks    <= c.on_ticks;
    cmd_if.step_ticks  <= c.step_ticks;
    cmd_if.muted       <= c.muted;
    cmd_if.loop_flag   <= c.loop_flag;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    tracker.accept_command(c);
  endtask

  // lower valid after the last item of a phase, then let the block go idle
  task automatic finish_phase();
    cmd_if.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [nsp_pkg::LEN_CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_length(v);
    settings++;
  endtask

  initial begin
    int u;
    int ph;
    nsp_player_check_pkg::note_cmd_t c;
    logic [nsp_pkg::LEN_CFG_W-1:0] phase_len [PHASES];

    tracker  = new();
    settings = 0;
    phase_len = '{7'd6, 7'd64, 7'd1, 7'd127, 7'd0, 7'd0, 7'd0};
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    cmd_if.valid       <= 1'b0;
    cmd_if.cmd         <= nsp_pkg::CMD_LOAD;
    cmd_if.entry_index <= '0;
    cmd_if.note_word   <= '0;
    cmd_if.on_ticks    <= '0;
    cmd_if.step_ticks  <= '0;
    cmd_if.muted       <= 1'b0;
    cmd_if.loop_flag   <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_length('0);

    // unknown codes, start with zero length, resume, tick and stop with no sequence
    for (u = nsp_player_check_pkg::CMD_UNKNOWN_LO; u <= nsp_player_check_pkg::CMD_UNKNOWN_HI;
         u++)
      send_command(make_cmd(nsp_pkg::CMD_W'(u), '1, '1, '1, '1, 1'b1, 1'b1));
    send_command(make_cmd(nsp_pkg::CMD_START, '0, '0, '0, '0, 1'b0, 1'b1));
    send_command(make_cmd(nsp_pkg::CMD_RESUME, '0, '0, '0, '0, 1'b0, 1'b1));
    send_command(make_cmd(nsp_pkg::CMD_TICK, '0, '0, '0, '0, 1'b0, 1'b0));
    send_command(make_cmd(nsp_pkg::CMD_STOP, '0, '0, '0, '0, 1'b0, 1'b0));

    send_command(make_cmd(nsp_pkg::CMD_LOAD, 6'd0, 16'h0000, 16'd0, 16'd1, 1'b0, 1'b0));
    send_command(make_cmd(nsp_pkg::CMD_LOAD, 6'd1, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 1'b0));
    send_command(make_cmd(nsp_pkg::CMD_LOAD, 6'd2, 16'h1234, 16'd3, 16'd2, 1'b1, 1'b0));
    send_command(make_cmd(nsp_pkg::CMD_LOAD, 6'd3, 16'h8001, 16'd2, 16'hFFFF, 1'b0, 1'b0));
    send_command(make_cmd(nsp_pkg::CMD_LOAD, 6'd4, 16'h5A5A, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    for (u = 5; u < 8; u++) begin
      c = random_load(8, 2);
      c.entry_index = nsp_pkg::INDEX_W'(u);
      send_command(c);
    end
    finish_phase();

    write_length(7'd4);
    send_command(make_cmd(nsp_pkg::CMD_START, '0, '0, '0, '0, 1'b0, 1'b0));
    repeat (6) send_command(make_cmd(nsp_pkg::CMD_TICK, '0, '0, '0, '0, 1'b0, 1'b0));
    send_command(make_cmd(nsp_pkg::CMD_STOP, '0, '0, '0, '0, 1'b0, 1'b0));
    finish_phase();

    // fill the rest of the store so every length is safe to play
    for (u = 8; u < nsp_pkg::SEQ_DEPTH; u++) begin
      c = random_load(30, 3);
      c.entry_index = nsp_pkg::INDEX_W'(u);
      send_command(c);
    end
    finish_phase();

    for (ph = 0; ph < PHASES; ph++) begin
      if (phase_len[ph] == 0 && ph >= 5)
        phase_len[ph] = nsp_pkg::LEN_CFG_W'($urandom_range(20, 2));
      write_length(phase_len[ph]);
      idle_pct = (ph == 1) ? 0 : IDLE_PCT;
      c = random_load(12, 4);
      c.cmd = nsp_pkg::CMD_START;
      send_command(c);
      repeat (PHASE_ITEMS) send_command(random_command());
      finish_phase();
    end
    idle_pct = IDLE_PCT;

    $display("%0d command items (%0d ticks) over %0d length settings", tracker.commands,
             tracker.ticks, settings);
    $display("%0d note events checked, %0d of them from a full active list", tracker.events,
             tracker.evictions);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
